### src/cbf_pkg.sv
// Shared types, constants and the interpolation function of the Bezier flattener.
`default_nettype none
package cbf_pkg;

   typedef logic signed [15:0] coord_type;
   typedef logic [16:0]        tpar_type;
   typedef logic [17:0]        tacc_type;

   localparam tpar_type T_ONE      = 17'd65536;
   localparam tacc_type T_LIMIT    = 18'd65543;
   localparam tpar_type STEP_MIN   = 17'd1040;
   localparam tpar_type STEP_RESET = 17'd1310;

   // Declared high to low so that p0_x lands in the lowest bits.
   typedef struct packed {
      coord_type p3_y;
      coord_type p3_x;
      coord_type p2_y;
      coord_type p2_x;
      coord_type p1_y;
      coord_type p1_x;
      coord_type p0_y;
      coord_type p0_x;
   } seg_type;

   typedef struct packed {
      tpar_type step;
      seg_type  seg;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_out_type;

   // Computes a + floor(t * (b - a) / 65536); the result stays between a and b.
   function automatic coord_type lerp(input coord_type a, input coord_type b,
                                      input tpar_type t);
      logic signed [16:0] diff;
      logic signed [34:0] prod;
      diff = 17'(signed'(b)) - 17'(signed'(a));
      prod = 35'(signed'({1'b0, t})) * 35'(diff);
      return a + coord_type'(prod[31:16]);
   endfunction

endpackage
`default_nettype wire

### src/cubic_bezier_flattener.sv
// Top level of the cubic Bezier flattener.
// Each segment transfer on the req_ side yields a run of curve points on the rsp_ side,
// one point per clock while the consumer keeps rsp_tready high: about 65536/step + 1
// points (51 at the reset step, never more than 64). The parameter sequencer issues one
// evaluation per cycle, while rsp_ is not stalled, into a three-stage interpolation
// pipeline; the point rate is set by that sequencer. A two-entry segment queue lets
// new segments be taken while the current run is still being produced, and a run
// follows the previous one without a gap. Points pass the s1, s2 and out registers
// on their way to rsp_. Write csr_ only while the block is idle.
`default_nettype none
module cubic_bezier_flattener (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (16 bits each, from bit 0 up)
   input  wire logic [127:0]        req_tdata,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // point_x [15:0], point_y [31:16]
   output logic [31:0]              rsp_tdata,
   output logic                     rsp_tlast,
   input  wire logic                csr_wr_en,
   input  wire logic [16:0]         csr_wr_data
);
   import cbf_pkg::*;

   queue_out_type q_out;
   logic          q_pop;

   cbf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (seg_type'(req_tdata)),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (tpar_type'(csr_wr_data)),
      .q_pop       (q_pop),
      .q_out       (q_out)
   );

   cbf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

### src/cbf_front.sv
// Front end: step register, segment intake and the two-entry segment queue.
`default_nettype none
module cbf_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire cbf_pkg::seg_type      req_tdata,
   input  wire logic                  csr_wr_en,
   input  wire cbf_pkg::tpar_type     csr_wr_data,
   input  wire logic                  q_pop,
   output cbf_pkg::queue_out_type     q_out
);
   import cbf_pkg::*;

   tpar_type  step_ff;
   tpar_type  step_eff;
   entry_type entries_ff [2];
   logic      wr_ptr_ff, wr_ptr_in;
   logic      rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic      accept;

   assign req_tready = (count_ff != 2'd2);
   assign accept     = req_tvalid && req_tready;
   assign step_eff   = (step_ff < STEP_MIN) ? STEP_MIN : step_ff;

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      case ({accept, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_RESET;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            step_ff <= csr_wr_data;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entries_ff[wr_ptr_ff] <= '{step: step_eff, seg: req_tdata};
      end
   end

endmodule
`default_nettype wire

### src/cbf_back.sv
// Back end: parameter sequencer and the three-level de Casteljau pipeline.
`default_nettype none
module cbf_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cbf_pkg::queue_out_type q_out,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,
   output logic                       rsp_tlast
);
   import cbf_pkg::*;

   logic      advance;
   logic      busy_ff;
   tacc_type  t_ff;
   seg_type   seg_ff;
   tpar_type  step_ff;
   tpar_type  tc;
   tacc_type  t_next;
   logic      last_now;

   logic      s1_valid_ff, s1_last_ff;
   tpar_type  s1_t_ff;
   coord_type ab_x_ff, bc_x_ff, cd_x_ff, ab_y_ff, bc_y_ff, cd_y_ff;

   logic      s2_valid_ff, s2_last_ff;
   tpar_type  s2_t_ff;
   coord_type abc_x_ff, bcd_x_ff, abc_y_ff, bcd_y_ff;

   logic      out_valid_ff, out_last_ff;
   coord_type px_ff, py_ff;

   assign advance  = !out_valid_ff || rsp_tready;
   assign tc       = (t_ff > tacc_type'(T_ONE)) ? T_ONE : t_ff[16:0];
   assign t_next   = tacc_type'(tc) + tacc_type'(step_ff);
   assign last_now = (t_next > T_LIMIT);
   assign q_pop    = advance && q_out.valid && (!busy_ff || last_now);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {py_ff, px_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         if (q_pop) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last_now) begin
            busy_ff <= 1'b0;
         end
         s1_valid_ff  <= busy_ff;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (q_pop) begin
            seg_ff  <= q_out.entry.seg;
            step_ff <= q_out.entry.step;
            t_ff    <= '0;
         end else begin
            t_ff <= t_next;
         end
         s1_last_ff <= last_now;
         s1_t_ff    <= tc;
         ab_x_ff    <= lerp(seg_ff.p0_x, seg_ff.p1_x, tc);
         bc_x_ff    <= lerp(seg_ff.p1_x, seg_ff.p2_x, tc);
         cd_x_ff    <= lerp(seg_ff.p2_x, seg_ff.p3_x, tc);
         ab_y_ff    <= lerp(seg_ff.p0_y, seg_ff.p1_y, tc);
         bc_y_ff    <= lerp(seg_ff.p1_y, seg_ff.p2_y, tc);
         cd_y_ff    <= lerp(seg_ff.p2_y, seg_ff.p3_y, tc);

         s2_last_ff <= s1_last_ff;
         s2_t_ff    <= s1_t_ff;
         abc_x_ff   <= lerp(ab_x_ff, bc_x_ff, s1_t_ff);
         bcd_x_ff   <= lerp(bc_x_ff, cd_x_ff, s1_t_ff);
         abc_y_ff   <= lerp(ab_y_ff, bc_y_ff, s1_t_ff);
         bcd_y_ff   <= lerp(bc_y_ff, cd_y_ff, s1_t_ff);

         out_last_ff <= s2_last_ff;
         px_ff       <= lerp(abc_x_ff, bcd_x_ff, s2_t_ff);
         py_ff       <= lerp(abc_y_ff, bcd_y_ff, s2_t_ff);
      end
   end

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the cubic Bezier flattener: segments in, predicted curve points out.
`default_nettype none
module tb_top;
   import cbf_pkg::*;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } curve_point_type;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 8;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_wr_en = 1'b0;
   logic [16:0]  csr_wr_data = '0;

   seg_type         pending_segs[$];
   curve_point_type expected_points[$];
   tpar_type        cur_step = STEP_RESET;
   int              send_idle_pct = 31;
   int              recv_idle_pct = 78;
   int              hold_req_count = 0;
   int              hold_ack_count = 0;
   int              hold_left = 0;
   int              quiet_cycles = 0;
   int              error_count = 0;

   cubic_bezier_flattener u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int interp_coord(input int a, input int b, input int t);
      longint prod;
      prod = longint'(t) * (longint'(b) - longint'(a));
      return a + int'(prod >>> 16);
   endfunction

   function automatic int curve_coord(input int a, input int b, input int c, input int d,
                                      input int t);
      int ab, bc, cd;
      ab = interp_coord(a, b, t);
      bc = interp_coord(b, c, t);
      cd = interp_coord(c, d, t);
      return interp_coord(interp_coord(ab, bc, t), interp_coord(bc, cd, t), t);
   endfunction

   function automatic void predict_curve_points(input seg_type s);
      int step, t, tc, n;
      curve_point_type p;
      step = (cur_step < STEP_MIN) ? int'(STEP_MIN) : int'(cur_step);
      t = 0;
      n = 0;
      while (t <= int'(T_LIMIT) && n < 64) begin
         tc = (t > int'(T_ONE)) ? int'(T_ONE) : t;
         p.x = coord_type'(curve_coord(int'(s.p0_x), int'(s.p1_x), int'(s.p2_x),
                                       int'(s.p3_x), tc));
         p.y = coord_type'(curve_coord(int'(s.p0_y), int'(s.p1_y), int'(s.p2_y),
                                       int'(s.p3_y), tc));
         p.last = (tc + step > int'(T_LIMIT));
         expected_points = {expected_points, p};
         n++;
         t = tc + step;
      end
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
      error_count++;
   endtask

   function automatic void append_seg(input seg_type s);
      pending_segs = {pending_segs, s};
   endfunction

   function automatic seg_type make_seg(input int x0, input int y0, input int x1, input int y1,
                                        input int x2, input int y2, input int x3, input int y3);
      seg_type s;
      s.p0_x = coord_type'(x0);
      s.p0_y = coord_type'(y0);
      s.p1_x = coord_type'(x1);
      s.p1_y = coord_type'(y1);
      s.p2_x = coord_type'(x2);
      s.p2_y = coord_type'(y2);
      s.p3_x = coord_type'(x3);
      s.p3_y = coord_type'(y3);
      return s;
   endfunction

   // Mostly full-range values, with the extremes and the values around zero mixed in.
   function automatic coord_type rand_coord();
      int pick;
      pick = $urandom_range(15);
      case (pick)
         0: begin
            return coord_type'(-32768);
         end
         1: begin
            return coord_type'(32767);
         end
         2: begin
            return coord_type'($urandom_range(2) - 1);
         end
         default: begin
            return coord_type'($urandom);
         end
      endcase
   endfunction

   task automatic queue_random_segs(input int count);
      seg_type s;
      @(negedge clock);
      repeat (count) begin
         s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord(), rand_coord()};
         append_seg(s);
      end
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_segs.size() != 0 || req_tvalid || expected_points.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_step(input tpar_type value);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      cur_step    <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_segs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_segs.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_ack_count != hold_req_count) begin
         hold_ack_count = hold_req_count;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_points
      curve_point_type want;
      coord_type got_x, got_y;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_curve_points(seg_type'(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got_x = rsp_tdata[15:0];
            got_y = rsp_tdata[31:16];
            if (expected_points.size() == 0) begin
               report_mismatch("point with none expected", int'(got_x), 0);
            end else begin
               want = expected_points.pop_front();
               if (got_x !== want.x) begin
                  report_mismatch("point_x", int'(got_x), int'(want.x));
               end
               if (got_y !== want.y) begin
                  report_mismatch("point_y", int'(got_y), int'(want.y));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch("last_point", int'(rsp_tlast), int'(want.last));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[cubic_bezier_flattener] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed segments at the reset step.
      @(negedge clock);
      append_seg(make_seg(0, 0, 0, 0, 0, 0, 0, 0));
      append_seg(make_seg(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      append_seg(make_seg(-32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768));
      append_seg(make_seg(-32768, 32767, 32767, -32768,
                          -32768, 32767, 32767, -32768));
      append_seg(make_seg(32767, -32768, -32768, 32767,
                          32767, -32768, -32768, 32767));
      append_seg(make_seg(-32768, -32768, -10923, -10923,
                          10922, 10922, 32767, 32767));
      append_seg(make_seg(-32768, 0, 32767, 32767, 32767, 32767, 0, -32768));
      append_seg(make_seg(0, 0, 32767, 32767, -32768, 32767, 0, 0));
      append_seg(make_seg(-1, 1, 1, -1, -1, 1, 1, -1));
      append_seg(make_seg(-1, -1, -1, -1, -1, -1, -1, -1));
      append_seg(make_seg(-32768, -32768, 32767, 32767,
                          32767, 32767, 32767, 32767));
      append_seg(make_seg(32767, 32767, -32768, -32768,
                          -32768, -32768, -32768, -32768));
      append_seg(make_seg(100, -200, 300, -400, 500, -600, 700, -800));

      write_step(17'd1040);
      queue_random_segs(40);
      write_step(17'd0);
      queue_random_segs(30);
      write_step(17'd65536);
      queue_random_segs(40);

      wait_drained();
      send_idle_pct = 78;
      recv_idle_pct = 31;
      write_step(17'd65540);
      queue_random_segs(40);
      write_step(17'd65543);
      queue_random_segs(30);
      write_step(17'd65544);
      queue_random_segs(30);
      write_step(17'd131071);
      queue_random_segs(30);

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_step(17'd500);
      @(negedge clock);
      hold_req_count++;
      queue_random_segs(40);
      write_step(17'd8192);
      queue_random_segs(50);
      write_step(tpar_type'($urandom_range(65536, 1040)));
      queue_random_segs(50);
      write_step(STEP_RESET);
      queue_random_segs(60);

      wait_drained();
      if (error_count == 0) begin
         $display("[cubic_bezier_flattener] OK");
      end else begin
         $display("[cubic_bezier_flattener] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

### cubic_bezier_flattener.f
src/cbf_pkg.sv
src/cbf_front.sv
src/cbf_back.sv
src/cubic_bezier_flattener.sv
dv/tb_top.sv
